>>> sv/sit_pkg.sv
// ----------------------------------------------------------------------------
// sit_pkg: shared types and constants of the sorted interval table
// Entry layout, operation and status codes, and sequencer states.
// ----------------------------------------------------------------------------
package sit_pkg;

  localparam int unsigned TimeW        = 13;
  localparam int unsigned RoomW        = 16;
  localparam int unsigned OccW         = 5;
  localparam int unsigned TimeFracBits = 8;
  localparam int unsigned DayLimit     = 24 << TimeFracBits;

  typedef struct packed {
    logic [RoomW-1:0] room;
    logic [TimeW-1:0] stop;
    logic [TimeW-1:0] start;
  } entry_t;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_FIND   = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_OVERLAP   = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_PLACE,
    S_RESP
  } state_e;

endpackage

>>> sv/sorted_interval_table_top.sv
// ----------------------------------------------------------------------------
// sorted_interval_table_top: sorted, non-overlapping interval table
// Up to CAPACITY half-open intervals [start, end) with a room tag, kept in
// RAM sorted by start. Insert, remove by start, find by start.
// ----------------------------------------------------------------------------
// One operation at a time; every operation gives exactly one result transfer.
// A find, a miss or an insert rejected for overlap or a full table reads every
// stored entry once through the single RAM read port, whose read data is
// registered, and then raises the result once the output register is free.
// An invalid insert or the unused action skips the scan. After the scan an
// insert moves the entries from its position upward up by one and then writes
// the new entry; a remove moves the entries above the match down by one. The
// input side is ready only while the sequencer is idle; a finished result
// waits in the output register while the next operation is taken.
module sorted_interval_table_top #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // start_hours[12:0], end_hours[25:13], room_tag[41:26]
  input  logic [1:0]  s_axis_tuser,   // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // hit_start[12:0], hit_end[25:13], hit_room[41:26],
                                      // occupancy[46:42]
  output logic [2:0]  m_axis_tuser    // status[2:0]
);

  import sit_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = $bits(entry_t);
  localparam logic [CW-1:0] CapCnt = CW'(CAPACITY);

  state_e        state_q, state_d;
  action_e       act_q, act_d;
  entry_t        req_q, req_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] scan_q, scan_d;
  logic          dv_q, dv_d;
  logic          ovl_q, ovl_d;
  logic          found_q, found_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [CW-1:0] match_q, match_d;
  logic [CW-1:0] src_q, src_d;
  logic          wv_q, wv_d;
  logic [AW-1:0] waddr_q, waddr_d;
  entry_t        hit_q, hit_d;
  status_e       status_q, status_d;

  logic          m_valid_q, m_valid_d;
  entry_t        out_hit_q, out_hit_d;
  status_e       out_st_q, out_st_d;
  logic [OccW-1:0] out_occ_q, out_occ_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;
  entry_t        rd;
  entry_t        in_ent;
  logic          in_acc;
  logic          in_bad;
  logic          issue;
  logic [CW+OccW-1:0] occ_ext;

  sit_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd = entry_t'(ram_rdata);

  assign in_ent.start = s_axis_tdata[12:0];
  assign in_ent.stop  = s_axis_tdata[25:13];
  assign in_ent.room  = s_axis_tdata[41:26];
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign in_bad  = (32'(in_ent.stop) > DayLimit) || (in_ent.start >= in_ent.stop);
  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    act_d     = act_q;
    req_d     = req_q;
    count_d   = count_q;
    scan_d    = scan_q;
    dv_d      = 1'b0;
    ovl_d     = ovl_q;
    found_d   = found_q;
    pos_d     = pos_q;
    match_d   = match_q;
    src_d     = src_q;
    wv_d      = 1'b0;
    waddr_d   = waddr_q;
    hit_d     = hit_q;
    status_d  = status_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    out_hit_d = out_hit_q;
    out_st_d  = out_st_q;
    out_occ_d = out_occ_q;
    ram_we    = 1'b0;
    ram_waddr = waddr_q;
    ram_wdata = ram_rdata;
    ram_raddr = scan_q[AW-1:0];
    issue     = 1'b0;
    occ_ext   = {{OccW{1'b0}}, count_q};

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          act_d   = action_e'(s_axis_tuser);
          req_d   = in_ent;
          scan_d  = '0;
          ovl_d   = 1'b0;
          found_d = 1'b0;
          pos_d   = '0;
          match_d = '0;
          hit_d   = '0;
          status_d = ST_OK;
          if (action_e'(s_axis_tuser) == ACT_NONE ||
              (action_e'(s_axis_tuser) == ACT_INSERT && in_bad)) begin
            status_d = ST_INVALID;
            state_d  = S_RESP;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        issue     = (scan_q < count_q);
        ram_raddr = scan_q[AW-1:0];
        dv_d      = issue;
        if (issue) begin
          scan_d = scan_q + 1'b1;
        end
        if (dv_q) begin
          if (req_q.start < rd.stop && req_q.stop > rd.start) begin
            ovl_d = 1'b1;
          end
          if (rd.start < req_q.start) begin
            pos_d = pos_q + 1'b1;
          end
          if (rd.start == req_q.start) begin
            found_d = 1'b1;
            match_d = scan_q - 1'b1;
            if (act_q == ACT_FIND) begin
              hit_d = rd;
            end
          end
        end
        if (!issue && !dv_q) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        unique case (act_q)
          ACT_INSERT: begin
            if (ovl_q) begin
              status_d = ST_OVERLAP;
              state_d  = S_RESP;
            end else if (count_q >= CapCnt) begin
              status_d = ST_FULL;
              state_d  = S_RESP;
            end else begin
              src_d   = count_q;
              state_d = S_SHIFT;
            end
          end
          ACT_REMOVE: begin
            if (!found_q) begin
              status_d = ST_NOT_FOUND;
              state_d  = S_RESP;
            end else begin
              src_d   = match_q + 1'b1;
              state_d = S_SHIFT;
            end
          end
          default: begin
            status_d = found_q ? ST_OK : ST_NOT_FOUND;
            state_d  = S_RESP;
          end
        endcase
      end
      S_SHIFT: begin
        ram_we    = wv_q;
        ram_waddr = waddr_q;
        ram_wdata = ram_rdata;
        if (act_q == ACT_INSERT) begin
          issue     = (src_q > pos_q);
          ram_raddr = AW'(src_q - 1'b1);
          if (issue) begin
            waddr_d = src_q[AW-1:0];
            src_d   = src_q - 1'b1;
          end
        end else begin
          issue     = (src_q < count_q);
          ram_raddr = src_q[AW-1:0];
          if (issue) begin
            waddr_d = AW'(src_q - 1'b1);
            src_d   = src_q + 1'b1;
          end
        end
        wv_d = issue;
        if (!issue && !wv_q) begin
          if (act_q == ACT_INSERT) begin
            state_d = S_PLACE;
          end else begin
            count_d = count_q - 1'b1;
            state_d = S_RESP;
          end
        end
      end
      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q[AW-1:0];
        ram_wdata = req_q;
        count_d   = count_q + 1'b1;
        state_d   = S_RESP;
      end
      S_RESP: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          out_hit_d = hit_q;
          out_st_d  = status_q;
          out_occ_d = occ_ext[OccW-1:0];
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
      dv_q      <= 1'b0;
      wv_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
      dv_q      <= dv_d;
      wv_q      <= wv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q     <= act_d;
    req_q     <= req_d;
    scan_q    <= scan_d;
    ovl_q     <= ovl_d;
    found_q   <= found_d;
    pos_q     <= pos_d;
    match_q   <= match_d;
    src_q     <= src_d;
    waddr_q   <= waddr_d;
    hit_q     <= hit_d;
    status_q  <= status_d;
    out_hit_q <= out_hit_d;
    out_st_q  <= out_st_d;
    out_occ_q <= out_occ_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, out_occ_q, out_hit_q.room, out_hit_q.stop, out_hit_q.start};
  assign m_axis_tuser  = out_st_q;

endmodule

>>> sv/sit_ram.sv
// ----------------------------------------------------------------------------
// sit_ram: generic simple dual-port RAM
// One write port, one read port, registered read data, no reset.
// ----------------------------------------------------------------------------
module sit_ram #(
  parameter int unsigned WIDTH = 42,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
